// ===== rtl/tpd_pkg.sv =====
`timescale 1ns / 1ps

package tpd_pkg;

  localparam int RawW = 16;
  localparam int FullW = 14;
  localparam int SpanW = 12;
  localparam int PixW = 13;
  localparam int TrackW = 14;
  localparam int MagW = 28;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 14;

  localparam logic [7:0] PEN_DOWN_HDR = 8'h81;
  localparam logic [7:0] PEN_UP_HDR = 8'h80;

  localparam logic [CfgIdxW-1:0] REG_X_SPAN = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_X_FULL = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_Y_SPAN = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_Y_FULL = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_Y_OFFSET = 3'd4;

  localparam logic [SpanW-1:0] X_SPAN_RESET = 12'd800;
  localparam logic [FullW-1:0] X_FULL_RESET = 14'd4090;
  localparam logic [SpanW-1:0] Y_SPAN_RESET = 12'd480;
  localparam logic [FullW-1:0] Y_FULL_RESET = 14'd4070;
  localparam logic [FullW-1:0] Y_OFFSET_RESET = 14'd30;

  localparam logic signed [TrackW-1:0] TRACK_MIN_RESET = 14'sd4096;
  localparam logic signed [TrackW-1:0] TRACK_MAX_RESET = 14'sd0;

  typedef struct packed {
    logic            is_release;
    logic [RawW-1:0] raw_x;
    logic [RawW-1:0] raw_y;
  } pkt_t;

  typedef struct packed {
    logic [SpanW-1:0] x_span;
    logic [FullW-1:0] x_full;
    logic [SpanW-1:0] y_span;
    logic [FullW-1:0] y_full;
    logic [FullW-1:0] y_offset;
  } cfg_t;

  // one restoring step: returns {remainder, quotient/dividend shift word}
  function automatic logic [FullW+MagW-1:0] div_step(input logic [FullW-1:0] rem,
                                                      input logic [MagW-1:0] quo,
                                                      input logic [FullW-1:0] den);
    logic [FullW:0] rem_sh;
    logic [FullW:0] diff;
    rem_sh = {rem, quo[MagW-1]};
    diff = rem_sh - {1'b0, den};
    if (rem_sh >= {1'b0, den}) begin
      div_step = {diff[FullW-1:0], quo[MagW-2:0], 1'b1};
    end else begin
      div_step = {rem_sh[FullW-1:0], quo[MagW-2:0], 1'b0};
    end
  endfunction

  // saturate sign and magnitude to a 13-bit signed pixel
  function automatic logic signed [PixW-1:0] sat_pix(input logic neg,
                                                     input logic [MagW-1:0] mag);
    logic [MagW-1:0] negv;
    negv = ~mag + 1'b1;
    if (!neg) begin
      sat_pix = (mag > MagW'(4095)) ? 13'sd4095 : $signed(mag[PixW-1:0]);
    end else begin
      sat_pix = (mag > MagW'(4096)) ? -13'sd4096 : $signed(negv[PixW-1:0]);
    end
  endfunction

endpackage

// ===== rtl/tpd_if.sv =====
`timescale 1ns / 1ps

interface tpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface tpd_out_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   is_release;
  logic signed [tpd_pkg::PixW-1:0]        pixel_x;
  logic signed [tpd_pkg::PixW-1:0]        pixel_y;
  logic signed [tpd_pkg::TrackW-1:0]      lowest_x;
  logic signed [tpd_pkg::PixW-1:0]        highest_x;
  logic signed [tpd_pkg::TrackW-1:0]      lowest_y;
  logic signed [tpd_pkg::PixW-1:0]        highest_y;

  modport source (output valid, output is_release, output pixel_x, output pixel_y,
                  output lowest_x, output highest_x, output lowest_y, output highest_y,
                  input ready);
  modport sink (input valid, input is_release, input pixel_x, input pixel_y,
                input lowest_x, input highest_x, input lowest_y, input highest_y,
                output ready);
endinterface

// ===== rtl/tpd_front.sv =====
`timescale 1ns / 1ps

module tpd_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      rx_byte,
  input  logic            q_full,
  output logic            push,
  output tpd_pkg::pkt_t   push_pkt
);

  localparam logic [2:0] P_IDLE = 3'd0;
  localparam logic [2:0] P_XLO = 3'd1;
  localparam logic [2:0] P_XHI = 3'd2;
  localparam logic [2:0] P_YLO = 3'd3;
  localparam logic [2:0] P_YHI = 3'd4;

  logic [2:0]                 phase;
  logic                       kind;
  logic [tpd_pkg::RawW-1:0]   raw_x;
  logic [7:0]                 y_low;
  logic                       take;

  assign in_ready = !((phase == P_YHI) && q_full);
  assign take = in_valid && in_ready;
  assign push = take && (phase == P_YHI);

  assign push_pkt.is_release = kind;
  assign push_pkt.raw_x = raw_x;
  assign push_pkt.raw_y = {1'b0, rx_byte, 7'b0} + {8'b0, y_low};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
      kind <= 1'b0;
    end else if (take) begin
      unique case (phase)
        P_IDLE: begin
          if (rx_byte == tpd_pkg::PEN_DOWN_HDR) begin
            kind <= 1'b0;
            phase <= P_XLO;
          end else if (rx_byte == tpd_pkg::PEN_UP_HDR) begin
            kind <= 1'b1;
            phase <= P_XLO;
          end
        end
        P_XLO: phase <= P_XHI;
        P_XHI: phase <= P_YLO;
        P_YLO: phase <= P_YHI;
        P_YHI: phase <= P_IDLE;
        default: phase <= P_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (phase == P_XLO) begin
        raw_x <= {8'b0, rx_byte};
      end
      if (phase == P_XHI) begin
        raw_x <= {1'b0, rx_byte, 7'b0} + raw_x;
      end
      if (phase == P_YLO) begin
        y_low <= rx_byte;
      end
    end
  end

endmodule

// ===== rtl/tpd_queue.sv =====
`timescale 1ns / 1ps

module tpd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  tpd_pkg::pkt_t   push_pkt,
  input  logic            pop,
  output logic            empty,
  output logic            full,
  output tpd_pkg::pkt_t   head
);

  tpd_pkg::pkt_t entries [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;

  assign empty = (count == 2'd0);
  assign full = (count == 2'd2);
  assign head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_pkt;
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue count out of range");
  assert property (@(posedge clk) disable iff (rst) (push && !pop) |=> !empty)
    else $error("queue empty after push");

endmodule

// ===== rtl/tpd_back.sv =====
`timescale 1ns / 1ps

module tpd_back (
  input  logic                clk,
  input  logic                rst,
  input  tpd_pkg::cfg_t       cfg,
  input  logic                q_empty,
  input  tpd_pkg::pkt_t       head,
  output logic                pop,
  tpd_out_if.source           out_ch
);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_MUL = 2'd1;
  localparam logic [1:0] B_DIV = 2'd2;
  localparam logic [1:0] B_FIN = 2'd3;
  localparam logic [4:0] LAST_STEP = 5'(tpd_pkg::MagW - 1);

  logic [1:0]                           state;
  logic [4:0]                           step;
  logic                                 kind;
  logic signed [tpd_pkg::RawW:0]        diff_x;
  logic signed [tpd_pkg::RawW:0]        diff_y;
  logic signed [29:0]                   prod_x;
  logic signed [29:0]                   prod_y;
  logic [29:0]                          abs_x;
  logic [29:0]                          abs_y;
  logic                                 neg_x;
  logic                                 neg_y;
  logic [tpd_pkg::FullW-1:0]            den_x;
  logic [tpd_pkg::FullW-1:0]            den_y;
  logic [tpd_pkg::FullW-1:0]            rem_x;
  logic [tpd_pkg::FullW-1:0]            rem_y;
  logic [tpd_pkg::MagW-1:0]             quo_x;
  logic [tpd_pkg::MagW-1:0]             quo_y;
  logic [tpd_pkg::FullW+tpd_pkg::MagW-1:0] step_x;
  logic [tpd_pkg::FullW+tpd_pkg::MagW-1:0] step_y;
  logic signed [tpd_pkg::PixW-1:0]      pix_x;
  logic signed [tpd_pkg::PixW-1:0]      pix_y;
  logic signed [tpd_pkg::TrackW-1:0]    min_x;
  logic signed [tpd_pkg::TrackW-1:0]    max_x;
  logic signed [tpd_pkg::TrackW-1:0]    min_y;
  logic signed [tpd_pkg::TrackW-1:0]    max_y;
  logic signed [tpd_pkg::TrackW-1:0]    min_x_next;
  logic signed [tpd_pkg::TrackW-1:0]    max_x_next;
  logic signed [tpd_pkg::TrackW-1:0]    min_y_next;
  logic signed [tpd_pkg::TrackW-1:0]    max_y_next;
  logic signed [tpd_pkg::TrackW-1:0]    pix_x_ext;
  logic signed [tpd_pkg::TrackW-1:0]    pix_y_ext;
  logic                                 load;

  assign pop = (state == B_IDLE) && !q_empty;
  assign load = (state == B_FIN) && (!out_ch.valid || out_ch.ready);

  assign prod_x = diff_x * $signed({1'b0, cfg.x_span});
  assign prod_y = diff_y * $signed({1'b0, cfg.y_span});
  assign abs_x = prod_x[29] ? 30'(-prod_x) : 30'(prod_x);
  assign abs_y = prod_y[29] ? 30'(-prod_y) : 30'(prod_y);

  assign step_x = tpd_pkg::div_step(rem_x, quo_x, den_x);
  assign step_y = tpd_pkg::div_step(rem_y, quo_y, den_y);

  assign pix_x = tpd_pkg::sat_pix(neg_x, quo_x);
  assign pix_y = tpd_pkg::sat_pix(neg_y, quo_y);
  assign pix_x_ext = tpd_pkg::TrackW'(pix_x);
  assign pix_y_ext = tpd_pkg::TrackW'(pix_y);

  // press packets only: min first, max only when min held
  always_comb begin
    min_x_next = min_x;
    max_x_next = max_x;
    min_y_next = min_y;
    max_y_next = max_y;
    if (!kind) begin
      if (pix_x_ext < min_x) begin
        min_x_next = pix_x_ext;
      end else if (pix_x_ext > max_x) begin
        max_x_next = pix_x_ext;
      end
      if (pix_y_ext < min_y) begin
        min_y_next = pix_y_ext;
      end else if (pix_y_ext > max_y) begin
        max_y_next = pix_y_ext;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      step <= 5'd0;
      out_ch.valid <= 1'b0;
      min_x <= tpd_pkg::TRACK_MIN_RESET;
      max_x <= tpd_pkg::TRACK_MAX_RESET;
      min_y <= tpd_pkg::TRACK_MIN_RESET;
      max_y <= tpd_pkg::TRACK_MAX_RESET;
    end else begin
      if (out_ch.valid && out_ch.ready && !load) begin
        out_ch.valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (pop) begin
            state <= B_MUL;
          end
        end
        B_MUL: begin
          step <= 5'd0;
          state <= B_DIV;
        end
        B_DIV: begin
          step <= step + 5'd1;
          if (step == LAST_STEP) begin
            state <= B_FIN;
          end
        end
        B_FIN: begin
          if (load) begin
            out_ch.valid <= 1'b1;
            min_x <= min_x_next;
            max_x <= max_x_next;
            min_y <= min_y_next;
            max_y <= max_y_next;
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind <= head.is_release;
      diff_x <= $signed({1'b0, head.raw_x});
      diff_y <= $signed({1'b0, head.raw_y}) - $signed({3'b0, cfg.y_offset});
    end
    if (state == B_MUL) begin
      neg_x <= prod_x[29];
      neg_y <= prod_y[29];
      quo_x <= abs_x[tpd_pkg::MagW-1:0];
      quo_y <= abs_y[tpd_pkg::MagW-1:0];
      rem_x <= '0;
      rem_y <= '0;
      den_x <= (cfg.x_full == '0) ? tpd_pkg::FullW'(1) : cfg.x_full;
      den_y <= (cfg.y_full == '0) ? tpd_pkg::FullW'(1) : cfg.y_full;
    end
    if (state == B_DIV) begin
      {rem_x, quo_x} <= step_x;
      {rem_y, quo_y} <= step_y;
    end
    if (load) begin
      out_ch.is_release <= kind;
      out_ch.pixel_x <= pix_x;
      out_ch.pixel_y <= pix_y;
      out_ch.lowest_x <= min_x_next;
      out_ch.highest_x <= max_x_next[tpd_pkg::PixW-1:0];
      out_ch.lowest_y <= min_y_next;
      out_ch.highest_y <= max_y_next[tpd_pkg::PixW-1:0];
    end
  end

  assert property (@(posedge clk) disable iff (rst) (state == B_DIV) |-> (step <= LAST_STEP))
    else $error("divider step past last bit");
  assert property (@(posedge clk) disable iff (rst) load |=> (state == B_IDLE && out_ch.valid))
    else $error("result not presented after load");
  assert property (@(posedge clk) disable iff (rst)
                   (min_x <= tpd_pkg::TRACK_MIN_RESET) && (max_x >= tpd_pkg::TRACK_MAX_RESET))
    else $error("x tracker out of range");
  assert property (@(posedge clk) disable iff (rst) (pop |-> !out_ch.valid || state == B_IDLE))
    else $error("pop outside idle");

endmodule

// ===== rtl/touch_packet_decoder_core.sv =====
`timescale 1ns / 1ps
// path: last byte in, packet queue, back-end idle/mul/div/fin, registered result
// throughput: one byte per cycle; last bytes wait while the two-entry queue is full
// the back end takes one packet at a time through the 28-step bit-serial divider
// reset: header hunt, empty queue, trackers min 4096 / max 0, registers to defaults

module touch_packet_decoder_core (
  input  logic                             clk,
  input  logic                             rst,
  tpd_in_if.sink                           in_ch,
  tpd_out_if.source                        out_ch,
  input  logic                             cfg_write,
  input  logic [tpd_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [tpd_pkg::CfgDataW-1:0]     cfg_data
);

  tpd_pkg::cfg_t cfg;
  tpd_pkg::pkt_t push_pkt;
  tpd_pkg::pkt_t head;
  logic          push;
  logic          pop;
  logic          q_empty;
  logic          q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_span <= tpd_pkg::X_SPAN_RESET;
      cfg.x_full <= tpd_pkg::X_FULL_RESET;
      cfg.y_span <= tpd_pkg::Y_SPAN_RESET;
      cfg.y_full <= tpd_pkg::Y_FULL_RESET;
      cfg.y_offset <= tpd_pkg::Y_OFFSET_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        tpd_pkg::REG_X_SPAN: cfg.x_span <= cfg_data[tpd_pkg::SpanW-1:0];
        tpd_pkg::REG_X_FULL: cfg.x_full <= cfg_data;
        tpd_pkg::REG_Y_SPAN: cfg.y_span <= cfg_data[tpd_pkg::SpanW-1:0];
        tpd_pkg::REG_Y_FULL: cfg.y_full <= cfg_data;
        tpd_pkg::REG_Y_OFFSET: cfg.y_offset <= cfg_data;
        default: ;
      endcase
    end
  end

  tpd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .rx_byte  (in_ch.rx_byte),
    .q_full   (q_full),
    .push     (push),
    .push_pkt (push_pkt)
  );

  tpd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_pkt (push_pkt),
    .pop      (pop),
    .empty    (q_empty),
    .full     (q_full),
    .head     (head)
  );

  tpd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_empty (q_empty),
    .head    (head),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule
